FILE: rtl/rlbs_pkg.sv
// rlbs_pkg: shared constants, payload types and stage structs for the rgb luma scaler
// used by every module under rtl; no dependencies
`timescale 1ns / 1ps

package rlbs_pkg;

	// bt.601 luma weights in units of 1/1000 and the matching scale factor
	localparam int unsigned WGT_W     = 10;
	localparam logic [WGT_W-1:0] WGT_RED   = 10'd299;
	localparam logic [WGT_W-1:0] WGT_GREEN = 10'd587;
	localparam logic [WGT_W-1:0] WGT_BLUE  = 10'd114;
	localparam logic [WGT_W-1:0] LUMA_SCALE = 10'd1000;

	// channel layout: index 2 red, 1 green, 0 blue
	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned COLOR_W  = NUM_CH * CHAN_W;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// widths: c*level, luma*1000 (max 255000), dividend (max 65025000)
	localparam int unsigned PROD_W   = 2 * CHAN_W;
	localparam int unsigned LUMA_W   = 18;
	localparam int unsigned NUM_W    = 26;

	// one divider cell per quotient bit, plus one for the saturation bit
	localparam int unsigned NUM_CELLS = CHAN_W + 1;
	localparam int unsigned QUO_W     = NUM_CELLS;

	// pipeline registers before the output register: luma, scale, divider cells
	localparam int unsigned NUM_STG   = NUM_CELLS + 2;

	typedef logic [CHAN_W-1:0] chan_t;

	// first stage: luma and per-channel product of color and level
	typedef struct packed {
		logic [NUM_CH-1:0][PROD_W-1:0] prod;
		logic [LUMA_W-1:0]             luma;
	} luma_t;

	// state carried along the divider chain
	typedef struct packed {
		logic [NUM_CH-1:0][NUM_W-1:0] rem;
		logic [NUM_W-1:0]             dvsr;
		logic [NUM_CH-1:0][QUO_W-1:0] quo;
		logic                         black;
	} div_t;

endpackage

FILE: rtl/rgb_luma_brightness_scaler_core.sv
// rgb_luma_brightness_scaler_core: scales an rgb color to a target bt.601 luma
// path: luma stage, scale stage, divider cells, then the output register
// throughput: one request per cycle when no result stalls, through the 9-cell restoring divider chain
// every stage holds its item under back pressure; bubbles collapse, so the input
// keeps accepting while a result waits, up to 12 requests in flight
// reset: arst_n clears all valid flags at once; payload registers are not reset
`timescale 1ns / 1ps

module rgb_luma_brightness_scaler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  logic [rlbs_pkg::COLOR_W-1:0] packed_color,
	input  logic [rlbs_pkg::CHAN_W-1:0]  target_level,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [rlbs_pkg::COLOR_W-1:0] scaled_color
);

	localparam int unsigned LAST = rlbs_pkg::NUM_STG - 1;

	logic [rlbs_pkg::NUM_STG-1:0] vld;
	logic [rlbs_pkg::NUM_STG:0]   ld;
	rlbs_pkg::luma_t              luma_s1;
	rlbs_pkg::div_t               chain [rlbs_pkg::NUM_CELLS+1];
	logic                         res_valid_q;
	logic [rlbs_pkg::COLOR_W-1:0] scaled_color_q;
	logic [rlbs_pkg::COLOR_W-1:0] result;

	// a stage loads when it is empty or its item moves on
	assign ld[rlbs_pkg::NUM_STG] = !res_valid_q || !res_stall;
	for (genvar k = 0; k < rlbs_pkg::NUM_STG; k++) begin : g_ld
		assign ld[k] = !vld[k] || ld[k+1];
	end

	assign pix_stall = !ld[0];

	// luma and products
	rlbs_luma_stage u_luma (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ld[0]),
		.vld_in       (pix_valid),
		.packed_color (packed_color),
		.target_level (target_level),
		.vld_s1       (vld[0]),
		.dat_s1       (luma_s1)
	);

	// dividends and divisor
	rlbs_scale_stage u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld[1]),
		.vld_in (vld[0]),
		.dat_in (luma_s1),
		.vld_s2 (vld[1]),
		.dat_s2 (chain[0])
	);

	// divider chain, saturation bit first
	for (genvar k = 0; k < rlbs_pkg::NUM_CELLS; k++) begin : g_div
		rlbs_div_cell u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.ld     (ld[k+2]),
			.vld_in (vld[k+1]),
			.dat_in (chain[k]),
			.vld_q  (vld[k+2]),
			.dat_q  (chain[k+1])
		);
	end

	// clamp and repack
	always_comb begin
		for (int k = 0; k < rlbs_pkg::NUM_CH; k++) begin
			if (chain[rlbs_pkg::NUM_CELLS].black) begin
				result[k*rlbs_pkg::CHAN_W +: rlbs_pkg::CHAN_W] = '0;
			end else if (chain[rlbs_pkg::NUM_CELLS].quo[k][rlbs_pkg::QUO_W-1]) begin
				result[k*rlbs_pkg::CHAN_W +: rlbs_pkg::CHAN_W] = rlbs_pkg::CHAN_MAX;
			end else begin
				result[k*rlbs_pkg::CHAN_W +: rlbs_pkg::CHAN_W] =
					chain[rlbs_pkg::NUM_CELLS].quo[k][rlbs_pkg::CHAN_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld[rlbs_pkg::NUM_STG]) begin
			res_valid_q <= vld[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[rlbs_pkg::NUM_STG] && vld[LAST]) begin
			scaled_color_q <= result;
		end
	end

	assign res_valid    = res_valid_q;
	assign scaled_color = scaled_color_q;

	// black input always leaves as black
	a_black_out: assert property (@(posedge clk) disable iff (!arst_n)
		ld[rlbs_pkg::NUM_STG] && vld[LAST] && chain[rlbs_pkg::NUM_CELLS].black
		|=> res_valid && (scaled_color == '0))
		else $error("black request did not produce a black result");

	// input back pressure only comes from a stalled result with a full pipeline
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall && (vld == '1))
		else $error("input stalled without a full, stalled pipeline");

	// a waiting result that gets taken is replaced by the last stage content
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall |=> res_valid == $past(vld[LAST]))
		else $error("output register lost or invented a request");

endmodule

FILE: rtl/rlbs_luma_stage.sv
// rlbs_luma_stage: first pipeline stage, weighted luma sum and color times level products
// depends on rlbs_pkg
`timescale 1ns / 1ps

module rlbs_luma_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ld,
	input  logic                          vld_in,
	input  logic [rlbs_pkg::COLOR_W-1:0]  packed_color,
	input  logic [rlbs_pkg::CHAN_W-1:0]   target_level,
	output logic                          vld_s1,
	output rlbs_pkg::luma_t               dat_s1
);

	rlbs_pkg::luma_t              nxt;
	rlbs_pkg::chan_t [rlbs_pkg::NUM_CH-1:0] chan;

	// unpack channels, weighted luma and per-channel products
	always_comb begin
		for (int k = 0; k < rlbs_pkg::NUM_CH; k++) begin
			chan[k] = packed_color[k*rlbs_pkg::CHAN_W +: rlbs_pkg::CHAN_W];
			nxt.prod[k] = rlbs_pkg::PROD_W'(chan[k]) * rlbs_pkg::PROD_W'(target_level);
		end
		nxt.luma = rlbs_pkg::LUMA_W'(chan[2]) * rlbs_pkg::LUMA_W'(rlbs_pkg::WGT_RED)
			+ rlbs_pkg::LUMA_W'(chan[1]) * rlbs_pkg::LUMA_W'(rlbs_pkg::WGT_GREEN)
			+ rlbs_pkg::LUMA_W'(chan[0]) * rlbs_pkg::LUMA_W'(rlbs_pkg::WGT_BLUE);
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld) begin
			vld_s1 <= vld_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ld && vld_in) begin
			dat_s1 <= nxt;
		end
	end

endmodule

FILE: rtl/rlbs_scale_stage.sv
// rlbs_scale_stage: second pipeline stage, builds dividends and the aligned divisor
// depends on rlbs_pkg
`timescale 1ns / 1ps

module rlbs_scale_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ld,
	input  logic            vld_in,
	input  rlbs_pkg::luma_t dat_in,
	output logic            vld_s2,
	output rlbs_pkg::div_t  dat_s2
);

	rlbs_pkg::div_t nxt;

	// dividend = c*level*1000, divisor = luma aligned to the top quotient bit
	always_comb begin
		for (int k = 0; k < rlbs_pkg::NUM_CH; k++) begin
			nxt.rem[k] = rlbs_pkg::NUM_W'(dat_in.prod[k])
				* rlbs_pkg::NUM_W'(rlbs_pkg::LUMA_SCALE);
		end
		nxt.dvsr  = {dat_in.luma, (rlbs_pkg::QUO_W-1)'(0)};
		nxt.quo   = '0;
		nxt.black = (dat_in.luma == '0);
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ld) begin
			vld_s2 <= vld_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ld && vld_in) begin
			dat_s2 <= nxt;
		end
	end

endmodule

FILE: rtl/rlbs_div_cell.sv
// rlbs_div_cell: one restoring-division step for all three channels, one quotient bit
// depends on rlbs_pkg
`timescale 1ns / 1ps

module rlbs_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ld,
	input  logic           vld_in,
	input  rlbs_pkg::div_t dat_in,
	output logic           vld_q,
	output rlbs_pkg::div_t dat_q
);

	rlbs_pkg::div_t              nxt;
	logic [rlbs_pkg::NUM_CH-1:0] ge;

	// compare and subtract, shift the quotient bit in, halve the divisor for the next cell
	always_comb begin
		for (int k = 0; k < rlbs_pkg::NUM_CH; k++) begin
			ge[k] = (dat_in.rem[k] >= dat_in.dvsr);
			nxt.rem[k] = ge[k] ? (dat_in.rem[k] - dat_in.dvsr) : dat_in.rem[k];
			nxt.quo[k] = {dat_in.quo[k][rlbs_pkg::QUO_W-2:0], ge[k]};
		end
		nxt.dvsr  = dat_in.dvsr >> 1;
		nxt.black = dat_in.black;
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ld) begin
			vld_q <= vld_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ld && vld_in) begin
			dat_q <= nxt;
		end
	end

endmodule
